### rtl/fcc_pkg.sv
// Shared types and constants for the frame cross correlation block.
// Holds the transaction payload structs, the register indexes and the cell control struct.
// No dependencies; every other file in rtl imports this package.
package fcc_pkg;

   // Default values of the top level parameters.
   localparam int MAX_LAGS_DEF    = 32;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int ACC_BITS_DEF    = 48;

   // Fixed widths of the transaction fields.
   localparam int SAMPLE_FIELD_BITS = 16;
   localparam int LAG_FIELD_BITS    = 5;
   localparam int CORR_FIELD_BITS   = 48;

   // Register port geometry and reset values.
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 5;
   localparam logic [LAG_FIELD_BITS-1:0] MAX_LAG_RESET   = 5'd31;
   localparam logic                      SELF_MODE_RESET = 1'b1;

   // Register indexes.
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MAX_LAG   = 2'd0,
      CSR_SELF_MODE = 2'd1
   } csr_index_type;

   // One input transaction: a sample pair and the end-of-frame flag.
   typedef struct packed {
      logic signed [SAMPLE_FIELD_BITS-1:0] x_sample;
      logic signed [SAMPLE_FIELD_BITS-1:0] y_sample;
      logic                                last_sample;
   } req_type;

   // One result transaction: the correlation value for one lag.
   typedef struct packed {
      logic [LAG_FIELD_BITS-1:0]         lag_index;
      logic signed [CORR_FIELD_BITS-1:0] corr_value;
      logic                              last_lag;
   } rsp_type;

   // Controls broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic shift;   // a sample pair is accepted this cycle
      logic close;   // the accepted pair ends the frame
      logic drain;   // sums move one cell toward the output
      logic clear;   // final drain cycle: clear all sums
   } cell_ctl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

endpackage

### rtl/fcc_cell.sv
// One lag cell: holds one history sample, one live bit, one product and one accumulator.
// Depends on fcc_pkg for the cell control struct.
// Samples move to the next lag each accepted pair; sums move toward lag 0 while draining.
module fcc_cell #(
   parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_BITS    = fcc_pkg::ACC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fcc_pkg::cell_ctl_type        ctl,
   input  logic signed [SAMPLE_BITS-1:0] x_from,
   input  logic                         live_from,
   input  logic signed [SAMPLE_BITS-1:0] y_sample,
   input  logic signed [ACC_BITS-1:0]   sum_from,
   output logic signed [SAMPLE_BITS-1:0] x_to,
   output logic                         live_to,
   output logic signed [ACC_BITS-1:0]   sum_to
);
   import fcc_pkg::*;

   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int SUM_BITS  = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
   localparam logic signed [SUM_BITS-1:0] SUM_HI =
      {{(SUM_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_LO =
      {{(SUM_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x_hist_ff, x_hist_in;
   logic                          live_ff, live_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                          prod_en_ff, prod_en_in;
   logic signed [ACC_BITS-1:0]    sum_ff, sum_in;
   logic signed [SUM_BITS-1:0]    sum_wide;
   logic signed [ACC_BITS-1:0]    sum_sat;

   // History and live bit shift one lag per accepted pair; the live bit marks
   // that this lag's sample belongs to the current frame.
   always_comb begin
      x_hist_in  = ctl.shift ? x_from : x_hist_ff;
      live_in    = ctl.shift ? (live_from & ~ctl.close) : live_ff;
      prod_in    = PROD_BITS'(x_from) * PROD_BITS'(y_sample);
      prod_en_in = ctl.shift & live_from;
   end

   // Saturating accumulate of the registered product.
   always_comb begin
      sum_wide = SUM_BITS'(sum_ff) + SUM_BITS'(prod_ff);
      if (sum_wide > SUM_HI) begin
         sum_sat = ACC_HI;
      end else if (sum_wide < SUM_LO) begin
         sum_sat = ACC_LO;
      end else begin
         sum_sat = ACC_BITS'(sum_wide);
      end
   end

   // Accumulator: clear ends a frame, drain shifts toward lag 0.
   always_comb begin
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.drain) begin
         sum_in = sum_from;
      end else if (prod_en_ff) begin
         sum_in = sum_sat;
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= 1'b0;
         prod_en_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         live_ff    <= live_in;
         prod_en_ff <= prod_en_in;
         sum_ff     <= sum_in;
      end
   end

   // Sample data needs no reset; the live bit masks stale history.
   always_ff @(posedge clock) begin
      x_hist_ff <= x_hist_in;
      prod_ff   <= prod_in;
   end

   assign x_to    = x_hist_ff;
   assign live_to = live_ff;
   assign sum_to  = sum_ff;

endmodule

### rtl/fcc_ctrl.sv
// Sequencer of the correlation row: runs frames, waits for the last product, drains results.
// Depends on fcc_pkg for the state enum and the cell control struct.
// Produces the broadcast cell controls, busy, and the result strobe with its lag number.
module fcc_ctrl #(
   parameter int MAX_LAGS = fcc_pkg::MAX_LAGS_DEF,
   localparam int LAG_W   = $clog2(MAX_LAGS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                last_in_frame,
   input  logic [fcc_pkg::LAG_FIELD_BITS-1:0]  max_lag,
   output fcc_pkg::cell_ctl_type               ctl,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic [LAG_W-1:0]                    lag_count,
   output logic                                last_lag
);
   import fcc_pkg::*;

   localparam int TOP_W = (LAG_W > LAG_FIELD_BITS) ? LAG_W : LAG_FIELD_BITS;

   state_type         state_ff, state_in;
   logic [LAG_W-1:0]  drain_ff, drain_in;
   logic [TOP_W-1:0]  top_lag;
   logic              drain_last;

   // Highest lag emitted: the register, limited to the row length.
   always_comb begin
      if (TOP_W'(max_lag) > TOP_W'(MAX_LAGS - 1)) begin
         top_lag = TOP_W'(MAX_LAGS - 1);
      end else begin
         top_lag = TOP_W'(max_lag);
      end
      drain_last = (TOP_W'(drain_ff) == top_lag);
   end

   // Next state and cell controls.
   always_comb begin
      state_in  = state_ff;
      drain_in  = drain_ff;
      ctl       = '0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               ctl.shift = 1'b1;
               if (last_in_frame) begin
                  ctl.close = 1'b1;
                  state_in  = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            drain_in = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (drain_last) begin
               ctl.clear = 1'b1;
               state_in  = ST_RUN;
            end else begin
               ctl.drain = 1'b1;
               drain_in  = drain_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

   assign busy      = (state_ff != ST_RUN);
   assign lag_count = drain_ff;
   assign last_lag  = rsp_valid & drain_last;

endmodule

### rtl/frame_cross_correlation_lags.sv
// Frame cross correlation over lags 0 to max_lag, built as a row of lag cells.
// Depends on fcc_pkg, fcc_cell and fcc_ctrl.
//
// Within a frame the block takes one sample pair per clock cycle; busy stays low. The
// pair flagged last_sample raises busy: the FLUSH state lets the row's registered products
// settle into the accumulators, then min(max_lag, MAX_LAGS-1)+1 results follow, one per
// cycle, lag 0 first, each marked by rsp_valid for exactly one cycle, the final one with
// last_lag. The receiver cannot stall, and the end of the burst is set by the drain of
// the accumulator chain toward the output cell, one lag per cycle. Busy falls after the
// final result. Configuration is written while busy is low and no frame is open; the
// block itself does not enforce this.
module frame_cross_correlation_lags #(
   parameter int MAX_LAGS    = fcc_pkg::MAX_LAGS_DEF,
   parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_BITS    = fcc_pkg::ACC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  fcc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output fcc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [fcc_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [fcc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import fcc_pkg::*;

   localparam int LAG_W = $clog2(MAX_LAGS);

   logic [LAG_FIELD_BITS-1:0]     max_lag_ff, max_lag_in;
   logic                          self_mode_ff, self_mode_in;
   logic                          accept;
   logic signed [SAMPLE_BITS-1:0] x_val, y_val;
   cell_ctl_type                  ctl;
   logic [LAG_W-1:0]              lag_count;
   logic                          last_lag;

   logic signed [SAMPLE_BITS-1:0] x_link [MAX_LAGS];
   logic                          live_link [MAX_LAGS];
   logic signed [ACC_BITS-1:0]    sum_link [MAX_LAGS+1];

   // Configuration registers; an unknown index is ignored.
   always_comb begin
      max_lag_in   = max_lag_ff;
      self_mode_in = self_mode_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_LAG:   max_lag_in   = csr_wdata[LAG_FIELD_BITS-1:0];
            CSR_SELF_MODE: self_mode_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lag_ff   <= MAX_LAG_RESET;
         self_mode_ff <= SELF_MODE_RESET;
      end else begin
         max_lag_ff   <= max_lag_in;
         self_mode_ff <= self_mode_in;
      end
   end

   // Samples are taken from the low bits of each field; a field narrower than SAMPLE_BITS is zero-extended.
   assign accept = start & ~busy;
   assign x_val  = $signed(SAMPLE_BITS'($unsigned(req_data.x_sample)));
   assign y_val  = self_mode_ff ? x_val
                                : $signed(SAMPLE_BITS'($unsigned(req_data.y_sample)));

   fcc_ctrl #(
      .MAX_LAGS(MAX_LAGS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .last_in_frame (req_data.last_sample),
      .max_lag       (max_lag_ff),
      .ctl           (ctl),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .lag_count     (lag_count),
      .last_lag      (last_lag)
   );

   // Row of lag cells: cell k correlates x[j-k] with the current y.
   assign x_link[0]          = x_val;
   assign live_link[0]       = 1'b1;
   assign sum_link[MAX_LAGS] = '0;

   for (genvar k = 0; k < MAX_LAGS; k++) begin : g_cell
      if (k < MAX_LAGS - 1) begin : g_mid
         fcc_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .ACC_BITS   (ACC_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .x_from    (x_link[k]),
            .live_from (live_link[k]),
            .y_sample  (y_val),
            .sum_from  (sum_link[k+1]),
            .x_to      (x_link[k+1]),
            .live_to   (live_link[k+1]),
            .sum_to    (sum_link[k])
         );
      end else begin : g_end
         fcc_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .ACC_BITS   (ACC_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .x_from    (x_link[k]),
            .live_from (live_link[k]),
            .y_sample  (y_val),
            .sum_from  (sum_link[k+1]),
            .x_to      (),
            .live_to   (),
            .sum_to    (sum_link[k])
         );
      end
   end

   // Result transaction comes from the lag 0 cell.
   always_comb begin
      rsp_data.lag_index  = LAG_FIELD_BITS'(lag_count);
      rsp_data.corr_value = CORR_FIELD_BITS'(sum_link[0]);
      rsp_data.last_lag   = last_lag;
   end

   // A result only appears while the block is busy.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result strobe while idle");

   // The pair that closes a frame makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_sample) |=> busy)
      else $error("frame close did not start the burst");

   // Lags within a burst come out in order, one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_lag) |=>
         (rsp_valid && rsp_data.lag_index == LAG_FIELD_BITS'($past(rsp_data.lag_index) + 1'b1)))
      else $error("burst lag order broken");

   // The burst ends after the result flagged as the last lag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_lag) |=> (!rsp_valid && !busy))
      else $error("burst continued past the last lag");

endmodule
